// File: sv/drs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance rank sorter package
// Shared sizes and the structs that run between the controller and the cells.
// ----------------------------------------------------------------------------
package drs_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int KEY_W       = 32;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int RANK_W      = IDX_W;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic              load_en;
      logic [IDX_W-1:0]  load_idx;
      logic [KEY_W-1:0]  load_key;
      logic              rank_init;
      logic              rank_step;
      logic              wb_en;
      logic [IDX_W-1:0]  wb_pos;
      logic [IDX_W-1:0]  wb_slot;
      logic [RANK_W-1:0] wb_rank;
   } cell_ctrl_type;

   // key that travels around the ring during ranking
   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
   } travel_type;

   // running best that travels down the chain during a pick
   typedef struct packed {
      logic              has;
      logic [RANK_W-1:0] best;
      logic [IDX_W-1:0]  pos;
      logic [IDX_W-1:0]  slot;
      logic [IDX_W-1:0]  tail_slot;
      logic [RANK_W-1:0] tail_rank;
   } token_type;

endpackage

// File: sv/drs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance rank sorter cell
// Holds one key slot and one remaining-list position; counts its rank from
// the key ring and updates the pick token as it passes.
// ----------------------------------------------------------------------------
module drs_cell
   import drs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] cell_idx,
   input  cell_ctrl_type    ctrl,
   input  travel_type       travel_prev,
   input  token_type        token_prev,
   input  logic             next_valid,
   output travel_type       travel_out,
   output token_type        token_out,
   output logic             valid_out
);

   logic [KEY_W-1:0]  key_ff,    key_in;
   logic              valid_ff,  valid_in;
   logic [RANK_W-1:0] rank_ff,   rank_in;
   logic [IDX_W-1:0]  slot_ff,   slot_in;
   travel_type        travel_ff, travel_in;
   token_type         token_ff,  token_in;
   logic              is_tail;

   assign is_tail = valid_ff & ~next_valid;

   always_comb begin
      key_in    = key_ff;
      valid_in  = valid_ff;
      rank_in   = rank_ff;
      slot_in   = slot_ff;
      travel_in = travel_ff;

      if (ctrl.load_en && (ctrl.load_idx == cell_idx)) begin
         key_in   = ctrl.load_key;
         valid_in = 1'b1;
      end

      if (ctrl.rank_init) begin
         travel_in.valid = valid_ff;
         travel_in.key   = key_ff;
         rank_in         = '0;
         slot_in         = cell_idx;
      end else if (ctrl.rank_step) begin
         // count the passing key if strictly smaller, then rotate
         travel_in = travel_prev;
         if (valid_ff && travel_ff.valid && (travel_ff.key < key_ff)) begin
            rank_in = rank_ff + 1'b1;
         end
      end

      if (ctrl.wb_en) begin
         // fill the picked position from the tail, drop the tail
         if (ctrl.wb_pos == cell_idx) begin
            slot_in = ctrl.wb_slot;
            rank_in = ctrl.wb_rank;
         end
         if (is_tail) begin
            valid_in = 1'b0;
         end
      end

      token_in = token_prev;
      if (valid_ff && (!token_prev.has || (rank_ff > token_prev.best))) begin
         token_in.has  = 1'b1;
         token_in.best = rank_ff;
         token_in.pos  = cell_idx;
         token_in.slot = slot_ff;
      end
      if (is_tail) begin
         token_in.tail_slot = slot_ff;
         token_in.tail_rank = rank_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      rank_ff   <= rank_in;
      slot_ff   <= slot_in;
      travel_ff <= travel_in;
      token_ff  <= token_in;
   end

   assign travel_out = travel_ff;
   assign token_out  = token_ff;
   assign valid_out  = valid_ff;

endmodule

// File: sv/distance_rank_sorter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance rank sorter core
// Collects a batch of distance keys and reports load slots farthest first.
// ----------------------------------------------------------------------------
// Usage: drive a request (req_distance_key, req_last_entry) with start while
// busy is low. Each request stores its key in the next load slot, up to
// MAX_ENTRIES; keys past that are dropped but a last flag still closes the
// batch. A request without the last flag yields nothing. After the last
// request busy rises and the block ranks the batch: a setup step, then a
// rotation of the keys once around the cell ring. For each result the pick
// token then walks down the chain of MAX_ENTRIES cells, one cell a cycle,
// and an emit step writes the pick back; results pass through one output
// register.
// Results show on rsp_* for exactly one cycle, marked by rsp_valid; the
// receiver cannot stall, so nothing is held. rsp_last_place marks the final
// result of the batch. Reset clears the control state and the cell valid
// bits; stored keys and ranks stay undefined until written.
// ----------------------------------------------------------------------------
module distance_rank_sorter_core
   import drs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [KEY_W-1:0] req_distance_key,
   input  logic             req_last_entry,
   output logic             rsp_valid,
   output logic [IDX_W-1:0] rsp_entry_slot,
   output logic [CNT_W-1:0] rsp_place_number,
   output logic             rsp_last_place
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_RANK,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] left_ff;
   logic [CNT_W-1:0] place_ff;
   logic [IDX_W-1:0] cyc_ff;
   logic             rsp_valid_ff;
   logic [IDX_W-1:0] rsp_entry_slot_ff;
   logic [CNT_W-1:0] rsp_place_number_ff;
   logic             rsp_last_place_ff;

   logic             accept;
   logic             cyc_done;
   cell_ctrl_type    ctrl;
   token_type        token_last;

   travel_type       travel_vec [MAX_ENTRIES];
   token_type        token_vec  [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] valid_vec;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign cyc_done = (cyc_ff == IDX_W'(MAX_ENTRIES - 1));

   // broadcast control: load on accept, rank while rotating, write back on emit
   always_comb begin
      ctrl.load_en   = accept && (count_ff < CNT_W'(MAX_ENTRIES));
      ctrl.load_idx  = count_ff[IDX_W-1:0];
      ctrl.load_key  = req_distance_key;
      ctrl.rank_init = (state_ff == ST_INIT);
      ctrl.rank_step = (state_ff == ST_RANK);
      ctrl.wb_en     = (state_ff == ST_EMIT);
      ctrl.wb_pos    = token_last.pos;
      ctrl.wb_slot   = token_last.tail_slot;
      ctrl.wb_rank   = token_last.tail_rank;
   end

   // the chain: ring for keys, straight line for the pick token
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      token_type token_prev;
      logic      next_valid;

      if (i == 0) begin : g_head
         assign token_prev = '0;
      end else begin : g_body
         assign token_prev = token_vec[i-1];
      end

      if (i == MAX_ENTRIES - 1) begin : g_end
         assign next_valid = 1'b0;
      end else begin : g_mid
         assign next_valid = valid_vec[i+1];
      end

      drs_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_idx    (IDX_W'(i)),
         .ctrl        (ctrl),
         .travel_prev (travel_vec[(i + MAX_ENTRIES - 1) % MAX_ENTRIES]),
         .token_prev  (token_prev),
         .next_valid  (next_valid),
         .travel_out  (travel_vec[i]),
         .token_out   (token_vec[i]),
         .valid_out   (valid_vec[i])
      );
   end

   assign token_last = token_vec[MAX_ENTRIES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= ST_IDLE;
         count_ff            <= '0;
         left_ff             <= '0;
         place_ff            <= '0;
         cyc_ff              <= '0;
         rsp_valid_ff        <= 1'b0;
         rsp_entry_slot_ff   <= '0;
         rsp_place_number_ff <= '0;
         rsp_last_place_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  // drop the key once the batch is full; the flag still counts
                  if (count_ff < CNT_W'(MAX_ENTRIES)) begin
                     count_ff <= count_ff + 1'b1;
                  end
                  if (req_last_entry) begin
                     state_ff <= ST_INIT;
                  end
               end
            end
            ST_INIT: begin
               // seed the ring and clear the ranks in the cells
               left_ff  <= count_ff;
               count_ff <= '0;
               place_ff <= CNT_W'(1);
               cyc_ff   <= '0;
               state_ff <= ST_RANK;
            end
            ST_RANK: begin
               // advance the ring once around
               cyc_ff <= cyc_ff + 1'b1;
               if (cyc_done) begin
                  cyc_ff   <= '0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               // wait for the token to clear the last cell
               cyc_ff <= cyc_ff + 1'b1;
               if (cyc_done) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               rsp_valid_ff        <= 1'b1;
               rsp_entry_slot_ff   <= token_last.slot;
               rsp_place_number_ff <= place_ff;
               rsp_last_place_ff   <= (left_ff == CNT_W'(1));
               place_ff            <= place_ff + 1'b1;
               left_ff             <= left_ff - 1'b1;
               cyc_ff              <= '0;
               if (left_ff == CNT_W'(1)) begin
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_SCAN;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_entry_slot   = rsp_entry_slot_ff;
   assign rsp_place_number = rsp_place_number_ff;
   assign rsp_last_place   = rsp_last_place_ff;

   // live cells must match the remaining count while picking
   a_valid_matches_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_EMIT) |->
         ($countones(valid_vec) == 32'(left_ff)))
      else $error("cell valid bits disagree with remaining count");

   // a pick always finds an entry
   a_emit_has_pick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> token_last.has)
      else $error("pick token empty at emit");

   // the final result returns the block to idle
   a_last_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_place_ff) |-> (state_ff == ST_IDLE))
      else $error("last result without return to idle");

   // after the last result no cell stays live
   a_empty_after_batch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_place_ff) |-> (valid_vec == '0))
      else $error("cells still live after final result");

   // load count never passes the cell count
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count overflow");

endmodule
